>>> rtl/core/nearest_target_steering_pwm_unit_macros.svh
// Assertion macros for the nearest-target steering PWM unit.
// Included by files that carry concurrent checks; empty under SYNTHESIS.
`ifndef NEAREST_TARGET_STEERING_PWM_UNIT_MACROS_SVH
`define NEAREST_TARGET_STEERING_PWM_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define NTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define NTS_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define NTS_ASSERT(lbl, clk, rstn, prop, msg)
`define NTS_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

>>> rtl/core/nts_pkg.sv
// Shared types and constants of the nearest-target steering PWM unit.
// No dependencies; used by nts_ctrl, nts_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package nts_pkg;

  localparam int IMG_W      = 12;
  localparam int CONF_W     = 8;
  localparam int THR_W      = 9;
  localparam int GAIN_W     = 16;
  localparam int SPD_W      = 17;
  localparam int CLASS_W    = 8;
  localparam int PWM_W      = 8;
  localparam int DIST_W     = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int Q16_ONE    = 65536;
  localparam int PWM_MAX    = 255;
  localparam int RATIO_W    = 20;
  localparam int RATIO_LO   = 13;
  localparam int RATIO_HI   = 27;

  localparam logic [IMG_W-1:0]  RST_IMG_W  = 12'd640;
  localparam logic [IMG_W-1:0]  RST_IMG_H  = 12'd480;
  localparam logic [THR_W-1:0]  RST_THR    = 9'd128;
  localparam logic [GAIN_W-1:0] RST_GAIN   = 16'd1049;
  localparam logic [SPD_W-1:0]  RST_BASE   = 17'd32768;
  localparam logic [SPD_W-1:0]  RST_SMOOTH = 17'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_CONF_THRESH   = 3'd2,
    CFG_STEER_GAIN    = 3'd3,
    CFG_BASE_SPEED    = 3'd4,
    CFG_SMOOTH_FACTOR = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_UPDATE,
    ST_OMEGA,
    ST_SPEED,
    ST_MIX,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic square;
    logic update;
    logic omega;
    logic speed;
    logic mix;
    logic commit;
  } nts_cmd_t;

  typedef struct packed {
    logic frame_last;
    logic out_free;
  } nts_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/nearest_target_steering_pwm_unit.sv
// The sequencer takes one request at a time through capture, filter, square
// and compare/update; a frame-last request also goes through omega, speed, mix
// and commit, and waits in commit on any output stall. Output register lets the
// next request enter while a result waits.
// Reset (async, active low): sequencer idle, best box and PWM history cleared,
// configuration back to its defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_target_steering_pwm_unit_macros.svh"
module nearest_target_steering_pwm_unit #(
  parameter int COORD_BITS = 12,
  parameter int MIN_SIDE   = 30
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     cfg_we_i,
  input  wire logic [nts_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  wire logic [nts_pkg::CFG_DATA_W-1:0]           cfg_data_i,
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // left_x, top_y, right_x, bottom_y, confidence, class_id
  input  wire logic [((4*COORD_BITS+16+7)/8)*8-1:0]     s_axis_tdata,
  // box_valid
  input  wire logic                                     s_axis_tuser,
  input  wire logic                                     s_axis_tlast,
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  // pwm_left, pwm_right, target_x, target_y, target_class
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0]          m_axis_tdata,
  // target_found
  output logic                                          m_axis_tuser
);
  import nts_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int TDO_W = ((2 * CB + 24 + 7) / 8) * 8;

  nts_cmd_t cmd;
  nts_sts_t sts;

  logic [PWM_W-1:0]   pwm_l, pwm_r;
  logic [CB-1:0]      tgt_x, tgt_y;
  logic [CLASS_W-1:0] tgt_cls;

  nts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nts_dp #(
    .COORD_BITS (COORD_BITS),
    .MIN_SIDE   (MIN_SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .box_valid_i    (s_axis_tuser),
    .left_x_i       (s_axis_tdata[CB-1:0]),
    .top_y_i        (s_axis_tdata[2*CB-1:CB]),
    .right_x_i      (s_axis_tdata[3*CB-1:2*CB]),
    .bottom_y_i     (s_axis_tdata[4*CB-1:3*CB]),
    .confidence_i   (s_axis_tdata[4*CB+CONF_W-1:4*CB]),
    .class_id_i     (s_axis_tdata[4*CB+CONF_W+CLASS_W-1:4*CB+CONF_W]),
    .frame_last_i   (s_axis_tlast),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .pwm_left_o     (pwm_l),
    .pwm_right_o    (pwm_r),
    .target_found_o (m_axis_tuser),
    .target_x_o     (tgt_x),
    .target_y_o     (tgt_y),
    .target_class_o (tgt_cls)
  );

  assign m_axis_tdata = TDO_W'({tgt_cls, tgt_y, tgt_x, pwm_r, pwm_l});

  `NTS_ASSERT(a_commit_slot_free, clk_i, rst_ni, cmd.commit |-> (!m_axis_tvalid || m_axis_tready), "result committed over a pending one")
  `NTS_ASSERT(a_busy_after_accept, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "request accepted while busy")
  `NTS_ASSERT(a_valid_from_commit, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(cmd.commit), "result valid without commit")
  `NTS_ASSERT_NEVER(a_no_target_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata[TDO_W-1:2*PWM_W] != '0), "target fields set without target")

endmodule
`default_nettype wire

>>> rtl/core/nts_ctrl.sv
// Sequencing state machine of the steering unit.
// Depends on nts_pkg; drives nts_dp through command/status structs.
`timescale 1ns / 1ps
`default_nettype none
module nts_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  nts_pkg::nts_sts_t      sts_i,
  output nts_pkg::nts_cmd_t      cmd_o
);
  import nts_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK:  state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_UPDATE;
      ST_UPDATE: state_d = sts_i.frame_last ? ST_OMEGA : ST_IDLE;
      ST_OMEGA:  state_d = ST_SPEED;
      ST_SPEED:  state_d = ST_MIX;
      ST_MIX:    state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK:  cmd_o.check  = 1'b1;
      ST_SQUARE: cmd_o.square = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_OMEGA:  cmd_o.omega  = 1'b1;
      ST_SPEED:  cmd_o.speed  = 1'b1;
      ST_MIX:    cmd_o.mix    = 1'b1;
      ST_COMMIT: cmd_o.commit = sts_i.out_free;
      default:   cmd_o        = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/nts_dp.sv
// Datapath of the steering unit: config registers, box filter, distance,
// best-box tracking, wheel speed and PWM smoothing. Depends on nts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nts_dp #(
  parameter int COORD_BITS = 12,
  parameter int MIN_SIDE   = 30
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  nts_pkg::nts_cmd_t                   cmd_i,
  output nts_pkg::nts_sts_t                   sts_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [nts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           box_valid_i,
  input  wire logic [COORD_BITS-1:0]          left_x_i,
  input  wire logic [COORD_BITS-1:0]          top_y_i,
  input  wire logic [COORD_BITS-1:0]          right_x_i,
  input  wire logic [COORD_BITS-1:0]          bottom_y_i,
  input  wire logic [nts_pkg::CONF_W-1:0]     confidence_i,
  input  wire logic [nts_pkg::CLASS_W-1:0]    class_id_i,
  input  wire logic                           frame_last_i,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic [nts_pkg::PWM_W-1:0]           pwm_left_o,
  output logic [nts_pkg::PWM_W-1:0]           pwm_right_o,
  output logic                                target_found_o,
  output logic [COORD_BITS-1:0]               target_x_o,
  output logic [COORD_BITS-1:0]               target_y_o,
  output logic [nts_pkg::CLASS_W-1:0]         target_class_o
);
  import nts_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int EW   = ((CB + 1 > IMG_W) ? CB + 1 : IMG_W) + 1;
  localparam int SQW  = 2 * EW;
  localparam int SUMW = SQW + 3;
  localparam int PW   = EW + GAIN_W + 1;
  localparam int OW   = PW - 5;
  localparam int VW   = OW + 2;
  localparam int DFW  = PWM_W + 1;
  localparam int MXW  = DFW + SPD_W + 1;
  localparam int STW  = MXW - 16;

  // configuration
  logic [IMG_W-1:0]  img_w_q, img_h_q;
  logic [THR_W-1:0]  thr_q;
  logic [GAIN_W-1:0] gain_q;
  logic [SPD_W-1:0]  base_q, smooth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= RST_IMG_W;
      img_h_q  <= RST_IMG_H;
      thr_q    <= RST_THR;
      gain_q   <= RST_GAIN;
      base_q   <= RST_BASE;
      smooth_q <= RST_SMOOTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   img_w_q  <= cfg_data_i[IMG_W-1:0];
        CFG_IMAGE_HEIGHT:  img_h_q  <= cfg_data_i[IMG_W-1:0];
        CFG_CONF_THRESH:   thr_q    <= cfg_data_i[THR_W-1:0];
        CFG_STEER_GAIN:    gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_BASE_SPEED:    base_q   <= cfg_data_i[SPD_W-1:0];
        CFG_SMOOTH_FACTOR: smooth_q <= cfg_data_i[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic                box_q, last_q;
  logic [CB-1:0]       lx_q, ty_q, rx_q, by_q;
  logic [CONF_W-1:0]   conf_q;
  logic [CLASS_W-1:0]  cls_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      box_q  <= box_valid_i;
      last_q <= frame_last_i;
      lx_q   <= left_x_i;
      ty_q   <= top_y_i;
      rx_q   <= right_x_i;
      by_q   <= bottom_y_i;
      conf_q <= confidence_i;
      cls_q  <= class_id_i;
    end
  end

  // filter, centre and offsets
  logic signed [CB:0]   w_c, h_c;
  logic [CB:0]          cx_sum, cy_sum;
  logic [CB-1:0]        cx_c, cy_c;
  logic signed [EW-1:0] dx_c, dy_c;
  logic                 keep_c;
  logic                 keep_q;
  logic signed [EW-1:0] dx_q, dy_q;
  logic [CB-1:0]        cx_q, cy_q;

  assign w_c    = $signed({1'b0, rx_q}) - $signed({1'b0, lx_q});
  assign h_c    = $signed({1'b0, by_q}) - $signed({1'b0, ty_q});
  assign cx_sum = {1'b0, lx_q} + {1'b0, w_c[CB:1]};
  assign cy_sum = {1'b0, ty_q} + {1'b0, h_c[CB:1]};
  assign cx_c   = cx_sum[CB-1:0];
  assign cy_c   = cy_sum[CB-1:0];
  assign dx_c   = $signed(EW'(img_w_q)) - $signed(EW'({cx_c, 1'b0}));
  assign dy_c   = $signed(EW'(img_h_q)) - $signed(EW'(cy_c));
  assign keep_c = box_q
               && ({1'b0, conf_q} >= thr_q)
               && (int'(w_c) >= MIN_SIDE)
               && (int'(h_c) >= MIN_SIDE)
               && (int'(w_c) * RATIO_W >= int'(h_c) * RATIO_LO)
               && (int'(w_c) * RATIO_W <= int'(h_c) * RATIO_HI);

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      keep_q <= keep_c;
      cx_q   <= cx_c;
      cy_q   <= cy_c;
      dx_q   <= dx_c;
      dy_q   <= dy_c;
    end
  end

  // squares
  logic signed [SQW-1:0] dx2_c, dy2_c;
  logic [SQW-1:0]        dx2_q, dy2_q;

  assign dx2_c = dx_q * dx_q;
  assign dy2_c = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      dx2_q <= $unsigned(dx2_c);
      dy2_q <= $unsigned(dy2_c);
    end
  end

  // best box of the frame
  logic [SUMW-1:0]    dist_sum;
  logic [DIST_W-1:0]  dist_c;
  logic               take_c;
  logic               have_q;
  logic [DIST_W-1:0]  best_d_q;
  logic [CB-1:0]      best_x_q, best_y_q;
  logic [CLASS_W-1:0] best_c_q;

  assign dist_sum = {3'b000, dx2_q} + {1'b0, dy2_q, 2'b00};
  assign dist_c   = dist_sum[DIST_W-1:0];
  assign take_c   = keep_q && (!have_q || (dist_c < best_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      best_d_q <= '0;
      best_x_q <= '0;
      best_y_q <= '0;
      best_c_q <= '0;
    end else if (cmd_i.commit) begin
      have_q   <= 1'b0;
      best_d_q <= '0;
      best_x_q <= '0;
      best_y_q <= '0;
      best_c_q <= '0;
    end else if (cmd_i.update && take_c) begin
      have_q   <= 1'b1;
      best_d_q <= dist_c;
      best_x_q <= cx_q;
      best_y_q <= cy_q;
      best_c_q <= cls_q;
    end
  end

  // turn rate
  logic signed [EW-1:0] e2_c;
  logic signed [PW-1:0] prod_c, prod_q;

  assign e2_c   = have_q ? ($signed(EW'(img_w_q)) - $signed(EW'({best_x_q, 1'b0}))) : '0;
  assign prod_c = $signed({1'b0, gain_q}) * e2_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.omega) prod_q <= prod_c;
  end

  // wheel speeds, clamp and scale to 0..255
  function automatic logic [SPD_W-1:0] clamp_spd(input logic signed [VW-1:0] v);
    if (v < 0) return '0;
    else if (v > Q16_ONE) return SPD_W'(Q16_ONE);
    else return v[SPD_W-1:0];
  endfunction

  function automatic logic [PWM_W-1:0] scale_raw(input logic [SPD_W-1:0] v);
    logic [SPD_W+7:0] t;
    t = {v, 8'h00} - {8'h00, v};
    return t[23:16];
  endfunction

  logic signed [OW-1:0] omega_c;
  logic signed [VW-1:0] base_x, vl_c, vr_c;
  logic [SPD_W-1:0]     s_sat_c, s_q;
  logic [PWM_W-1:0]     raw_l_q, raw_r_q;

  assign omega_c = $signed(prod_q[PW-1:5]);
  assign base_x  = $signed(VW'(base_q));
  assign vl_c    = base_x - VW'(omega_c);
  assign vr_c    = base_x + VW'(omega_c);
  assign s_sat_c = (smooth_q > SPD_W'(Q16_ONE)) ? SPD_W'(Q16_ONE) : smooth_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.speed) begin
      raw_l_q <= scale_raw(clamp_spd(vl_c));
      raw_r_q <= scale_raw(clamp_spd(vr_c));
      s_q     <= s_sat_c;
    end
  end

  // smoothing against previous PWM
  logic [PWM_W-1:0]      prev_l_q, prev_r_q;
  logic signed [DFW-1:0] dl_c, dr_c;
  logic signed [MXW-1:0] ml_c, mr_c, ml_q, mr_q;

  assign dl_c = $signed({1'b0, raw_l_q}) - $signed({1'b0, prev_l_q});
  assign dr_c = $signed({1'b0, raw_r_q}) - $signed({1'b0, prev_r_q});
  assign ml_c = dl_c * $signed({1'b0, s_q});
  assign mr_c = dr_c * $signed({1'b0, s_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      ml_q <= ml_c;
      mr_q <= mr_c;
    end
  end

  function automatic logic [PWM_W-1:0] pwm_next(input logic [PWM_W-1:0] prev,
                                                input logic signed [MXW-1:0] m);
    logic signed [STW-1:0] v;
    v = $signed(STW'(prev)) + $signed(m[MXW-1:16]);
    if (v < 0) return '0;
    else if (v > PWM_MAX) return PWM_W'(PWM_MAX);
    else return v[PWM_W-1:0];
  endfunction

  logic [PWM_W-1:0] pwm_l_c, pwm_r_c;

  assign pwm_l_c = pwm_next(prev_l_q, ml_q);
  assign pwm_r_c = pwm_next(prev_r_q, mr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q <= '0;
      prev_r_q <= '0;
    end else if (cmd_i.commit) begin
      prev_l_q <= pwm_l_c;
      prev_r_q <= pwm_r_c;
    end
  end

  // output register
  logic               out_valid_q;
  logic [PWM_W-1:0]   out_pl_q, out_pr_q;
  logic               out_found_q;
  logic [CB-1:0]      out_x_q, out_y_q;
  logic [CLASS_W-1:0] out_cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_pl_q    <= pwm_l_c;
      out_pr_q    <= pwm_r_c;
      out_found_q <= have_q;
      out_x_q     <= best_x_q;
      out_y_q     <= best_y_q;
      out_cls_q   <= best_c_q;
    end
  end

  assign sts_o.frame_last = last_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign pwm_left_o     = out_pl_q;
  assign pwm_right_o    = out_pr_q;
  assign target_found_o = out_found_q;
  assign target_x_o     = out_x_q;
  assign target_y_o     = out_y_q;
  assign target_class_o = out_cls_q;

endmodule
`default_nettype wire
